// File: design/lccv_pkg.sv
`default_nettype none
package lccv_pkg;

  // Cache geometry
  localparam int CACHE_ENTRIES = 128;
  localparam int IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int ID_W      = 10;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 16;
  localparam int OUT_IDX_W = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Command codes
  localparam logic [FUNC_W-1:0] FN_LOOKUP  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CONFIRM = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DATA    = 2'd2;

  // Scan unit modes
  typedef enum logic {
    SM_MATCH,
    SM_OLDEST
  } scan_mode_t;

  typedef struct packed {
    logic              start;
    scan_mode_t        mode;
    logic [FILL_W-1:0] limit;
    logic [TIME_W-1:0] key;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } scan_sts_t;

endpackage
`default_nettype wire

// File: design/lccv_if.sv
`default_nettype none
// Request channel
interface lccv_req_if;
  logic                           valid;
  logic                           ready;
  logic [lccv_pkg::FUNC_W-1:0]    func;
  logic [lccv_pkg::ID_W-1:0]      item_id;
  logic [lccv_pkg::TIME_W-1:0]    now_time;
  logic [lccv_pkg::TIME_W-1:0]    item_time;
  logic [lccv_pkg::VAL_W-1:0]     item_value;
  logic                           item_class;

  modport source (output valid, func, item_id, now_time, item_time, item_value, item_class,
                  input ready);
  modport sink   (input valid, func, item_id, now_time, item_time, item_value, item_class,
                  output ready);
endinterface

// Response channel
interface lccv_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lccv_pkg::OUT_IDX_W-1:0]  entry_index;
  logic [lccv_pkg::TIME_W-1:0]     cached_time;
  logic [lccv_pkg::CNT_W-1:0]      query_count;
  logic [lccv_pkg::CNT_W-1:0]      hit_count;
  logic                            warm;

  modport source (output valid, hit, entry_index, cached_time, query_count, hit_count, warm,
                  input ready);
  modport sink   (input valid, hit, entry_index, cached_time, query_count, hit_count, warm,
                  output ready);
endinterface
`default_nettype wire

// File: design/lccv_ram.sv
`default_nettype none
// Single write port, single registered read port
module lccv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/lccv_scan.sv
`default_nettype none
// Entry scanner: steps one entry per cycle through the tag / use-time read port
// with a single comparator. Match mode stops at the first tag hit; oldest mode
// tracks the smallest nonzero use time below the key.
module lccv_scan (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lccv_pkg::scan_ctl_t           ctl,
  input  wire logic [lccv_pkg::ID_W-1:0]     tag_rdata,
  input  wire logic [lccv_pkg::TIME_W-1:0]   use_rdata,
  output logic      [lccv_pkg::IDX_W-1:0]    addr,
  output lccv_pkg::scan_sts_t                sts
);

  logic                            running;
  logic [lccv_pkg::FILL_W-1:0]     cnt;
  logic [lccv_pkg::FILL_W-1:0]     limit;
  logic                            cmp_vld;
  logic [lccv_pkg::IDX_W-1:0]      cmp_idx;
  lccv_pkg::scan_mode_t            mode;
  logic [lccv_pkg::TIME_W-1:0]     key;
  logic [lccv_pkg::TIME_W-1:0]     best;
  logic [lccv_pkg::IDX_W-1:0]      best_idx;
  logic                            found;
  logic                            done;

  logic [lccv_pkg::TIME_W-1:0]     cmp_a;
  logic [lccv_pkg::TIME_W-1:0]     cmp_b;
  logic                            take;

  // Shared comparator
  always_comb begin
    if (mode == lccv_pkg::SM_MATCH) begin
      cmp_a = lccv_pkg::TIME_W'(tag_rdata);
      cmp_b = key;
      take  = (cmp_a == cmp_b);
    end else begin
      cmp_a = use_rdata;
      cmp_b = best;
      take  = (cmp_a < cmp_b) && (use_rdata != '0);
    end
  end

  assign addr = cnt[lccv_pkg::IDX_W-1:0];
  assign sts  = '{done: done, found: found, idx: best_idx};

  // Address issue, compare stage and result tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running  <= 1'b1;
        cnt      <= '0;
        limit    <= ctl.limit;
        mode     <= ctl.mode;
        key      <= ctl.key;
        best     <= ctl.key;
        best_idx <= '0;
        found    <= 1'b0;
        cmp_vld  <= 1'b0;
      end else if (running) begin
        if (cnt != limit) begin
          cmp_vld <= 1'b1;
          cmp_idx <= cnt[lccv_pkg::IDX_W-1:0];
          cnt     <= cnt + lccv_pkg::FILL_W'(1);
        end else begin
          cmp_vld <= 1'b0;
        end
        if (cmp_vld && take) begin
          best_idx <= cmp_idx;
          best     <= use_rdata;
          if (mode == lccv_pkg::SM_MATCH) begin
            found   <= 1'b1;
            running <= 1'b0;
            done    <= 1'b1;
            cmp_vld <= 1'b0;
          end
        end else if (!cmp_vld && cnt == limit) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/lru_client_cache_validator_core.sv
`default_nettype none
// Fully associative 128-entry client cache with timestamp LRU replacement.
// One request is in flight at a time; req.ready is high only while idle and
// the response register is free or being drained. Lookups, and data replies on
// a miss with the cache full (victim search), run the entry scanner, which reads
// one entry per cycle through the tag and use-time RAM ports and checks it with
// one comparator: a lookup scans the filled entries, a victim search all 128.
// Other requests skip the scanner, and any response may wait for rsp.ready.
// No clearing pass is needed after reset: entries beyond the fill count are
// never read.
module lru_client_cache_validator_core (
  input  wire logic  clk,
  input  wire logic  rst,
  lccv_req_if.sink   req,
  lccv_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_TADDR,
    ST_TDATA,
    ST_DONE
  } state_t;

  state_t state;

  // Captured request
  logic [lccv_pkg::FUNC_W-1:0]  func_r;
  logic [lccv_pkg::ID_W-1:0]    id_r;
  logic [lccv_pkg::TIME_W-1:0]  now_r;
  logic [lccv_pkg::TIME_W-1:0]  itime_r;
  logic [lccv_pkg::VAL_W-1:0]   ival_r;
  logic                         hot_r;

  // Cache control state
  logic [lccv_pkg::FILL_W-1:0]  fill_count;
  logic [lccv_pkg::IDX_W-1:0]   pending_index;
  logic                         pending_miss;
  logic [lccv_pkg::CNT_W-1:0]   queries;
  logic [lccv_pkg::CNT_W-1:0]   hits;
  logic                         warm_flag;

  // Result being built
  logic                         res_hit;
  logic [lccv_pkg::IDX_W-1:0]   res_idx;
  logic [lccv_pkg::TIME_W-1:0]  res_time;

  // Response register
  logic                            out_valid;
  logic                            out_hit;
  logic [lccv_pkg::OUT_IDX_W-1:0]  out_idx;
  logic [lccv_pkg::TIME_W-1:0]     out_time;
  logic [lccv_pkg::CNT_W-1:0]      out_queries;
  logic [lccv_pkg::CNT_W-1:0]      out_hits;
  logic                            out_warm;

  // RAM and scanner wiring
  lccv_pkg::scan_ctl_t          scan_ctl;
  lccv_pkg::scan_sts_t          sts;
  logic [lccv_pkg::IDX_W-1:0]   scan_addr;
  logic [lccv_pkg::ID_W-1:0]    tag_rdata;
  logic [lccv_pkg::TIME_W-1:0]  use_rdata;
  logic [lccv_pkg::TIME_W-1:0]  it_rdata;
  logic [lccv_pkg::VAL_W:0]     data_rdata;
  logic                         ent_we;
  logic                         use_we;
  logic [lccv_pkg::IDX_W-1:0]   wr_idx;
  logic                         fill_full;
  logic                         in_xfer;
  logic                         out_free;

  assign fill_full = (fill_count == lccv_pkg::FILL_W'(lccv_pkg::CACHE_ENTRIES));
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign in_xfer   = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.entry_index = out_idx;
  assign rsp.cached_time = out_time;
  assign rsp.query_count = out_queries;
  assign rsp.hit_count   = out_hits;
  assign rsp.warm        = out_warm;

  // Scanner start
  always_comb begin
    scan_ctl.start = (state == ST_EXEC) &&
                     ((func_r == lccv_pkg::FN_LOOKUP) ||
                      ((func_r == lccv_pkg::FN_DATA) && pending_miss && fill_full));
    if (func_r == lccv_pkg::FN_LOOKUP) begin
      scan_ctl.mode  = lccv_pkg::SM_MATCH;
      scan_ctl.limit = fill_count;
      scan_ctl.key   = lccv_pkg::TIME_W'(id_r);
    end else begin
      scan_ctl.mode  = lccv_pkg::SM_OLDEST;
      scan_ctl.limit = lccv_pkg::FILL_W'(lccv_pkg::CACHE_ENTRIES);
      scan_ctl.key   = now_r;
    end
  end

  // Write port control
  always_comb begin
    if (state == ST_SCAN) begin
      wr_idx = sts.idx;
    end else if (!pending_miss) begin
      wr_idx = pending_index;
    end else begin
      wr_idx = fill_count[lccv_pkg::IDX_W-1:0];
    end
    ent_we = ((state == ST_EXEC) && (func_r == lccv_pkg::FN_DATA) &&
              (!pending_miss || !fill_full)) ||
             ((state == ST_SCAN) && (func_r == lccv_pkg::FN_DATA) && sts.done);
    use_we = ent_we ||
             ((state == ST_EXEC) && (func_r == lccv_pkg::FN_CONFIRM) && !pending_miss);
  end

  lccv_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .tag_rdata (tag_rdata),
    .use_rdata (use_rdata),
    .addr      (scan_addr),
    .sts       (sts)
  );

  lccv_ram #(.WIDTH(lccv_pkg::ID_W), .DEPTH(lccv_pkg::CACHE_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_idx),
    .wdata (id_r),
    .raddr (scan_addr),
    .rdata (tag_rdata)
  );

  lccv_ram #(.WIDTH(lccv_pkg::TIME_W), .DEPTH(lccv_pkg::CACHE_ENTRIES)) u_itime_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_idx),
    .wdata (itime_r),
    .raddr (pending_index),
    .rdata (it_rdata)
  );

  // Payload word and class of each entry
  lccv_ram #(.WIDTH(lccv_pkg::VAL_W + 1), .DEPTH(lccv_pkg::CACHE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_idx),
    .wdata ({hot_r, ival_r}),
    .raddr (pending_index),
    .rdata (data_rdata)
  );

  // Use times of entries past the fill count are never read, so no reset sweep
  lccv_ram #(.WIDTH(lccv_pkg::TIME_W), .DEPTH(lccv_pkg::CACHE_ENTRIES)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (wr_idx),
    .wdata (now_r),
    .raddr (scan_addr),
    .rdata (use_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      pending_index <= '0;
      pending_miss  <= 1'b1;
      queries       <= '0;
      hits          <= '0;
      warm_flag     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            func_r  <= req.func;
            id_r    <= req.item_id;
            now_r   <= req.now_time;
            itime_r <= req.item_time;
            ival_r  <= req.item_value;
            hot_r   <= req.item_class;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_hit  <= 1'b0;
          res_idx  <= '0;
          res_time <= '0;
          case (func_r)
            lccv_pkg::FN_LOOKUP: begin
              if (queries != lccv_pkg::CNT_MAX) begin
                queries <= queries + lccv_pkg::CNT_W'(1);
              end
              state <= ST_SCAN;
            end
            lccv_pkg::FN_CONFIRM: begin
              res_idx <= pending_index;
              if (!pending_miss) begin
                if (hits != lccv_pkg::CNT_MAX) begin
                  hits <= hits + lccv_pkg::CNT_W'(1);
                end
                state <= ST_TADDR;
              end else begin
                state <= ST_DONE;
              end
            end
            lccv_pkg::FN_DATA: begin
              if (!pending_miss || !fill_full) begin
                res_idx  <= wr_idx;
                res_time <= itime_r;
                if (pending_miss) begin
                  fill_count <= fill_count + lccv_pkg::FILL_W'(1);
                end
                state <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_SCAN: begin
          if (sts.done) begin
            if (func_r == lccv_pkg::FN_LOOKUP) begin
              if (sts.found) begin
                pending_index <= sts.idx;
                pending_miss  <= 1'b0;
                res_hit       <= 1'b1;
                res_idx       <= sts.idx;
                state         <= ST_TADDR;
              end else begin
                pending_index <= '0;
                pending_miss  <= 1'b1;
                state         <= ST_DONE;
              end
            end else begin
              // Victim replaced; the first one ends the cold phase
              res_idx  <= sts.idx;
              res_time <= itime_r;
              if (!warm_flag) begin
                warm_flag <= 1'b1;
                queries   <= '0;
                hits      <= '0;
              end
              state <= ST_DONE;
            end
          end
        end
        ST_TADDR: begin
          state <= ST_TDATA;
        end
        ST_TDATA: begin
          res_time <= it_rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_hit     <= res_hit;
            out_idx     <= lccv_pkg::OUT_IDX_W'(res_idx);
            out_time    <= res_time;
            out_queries <= queries;
            out_hits    <= hits;
            out_warm    <= warm_flag;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= lccv_pkg::FILL_W'(lccv_pkg::CACHE_ENTRIES))
    else $error("fill count beyond cache size");

  a_warm_full: assert property (@(posedge clk) disable iff (rst)
    warm_flag |-> fill_full)
    else $error("warm before cache full");

  a_hit_pending: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |-> !pending_miss)
    else $error("hit reported with a pending miss");

  a_scan_done_state: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == ST_SCAN))
    else $error("scan finished outside scan state");
`endif

endmodule
`default_nettype wire

// File: dv/tb_lru_client_cache_validator_core.sv
`timescale 1ns / 100ps
module tb_lru_client_cache_validator_core;

  // Selector value with no command behind it
  localparam logic [lccv_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RAND_ITEMS      = 300;

  typedef struct packed {
    logic [lccv_pkg::FUNC_W-1:0] func;
    logic [lccv_pkg::ID_W-1:0]   item_id;
    logic [lccv_pkg::TIME_W-1:0] now_time;
    logic [lccv_pkg::TIME_W-1:0] item_time;
    logic [lccv_pkg::VAL_W-1:0]  item_value;
    logic                        item_class;
  } cache_req_t;

  typedef struct packed {
    logic                           hit;
    logic [lccv_pkg::OUT_IDX_W-1:0] entry_index;
    logic [lccv_pkg::TIME_W-1:0]    cached_time;
    logic [lccv_pkg::CNT_W-1:0]     query_count;
    logic [lccv_pkg::CNT_W-1:0]     hit_count;
    logic                           warm;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lccv_req_if req_ch ();
  lccv_rsp_if rsp_ch ();

  lru_client_cache_validator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the cache contents and bookkeeping
  logic [lccv_pkg::ID_W-1:0]   cache_tag       [lccv_pkg::CACHE_ENTRIES];
  logic [lccv_pkg::TIME_W-1:0] cache_item_time [lccv_pkg::CACHE_ENTRIES];
  logic [lccv_pkg::TIME_W-1:0] cache_use_time  [lccv_pkg::CACHE_ENTRIES];
  int                          cache_fill;
  int                          pend_idx;
  bit                          pend_miss;
  logic [lccv_pkg::CNT_W-1:0]  query_cnt;
  logic [lccv_pkg::CNT_W-1:0]  hit_cnt;
  bit                          warm_st;

  cache_rsp_t                  expected_rsp_q [$];
  int                          fail_cnt = 0;
  bit                          idle_en = 1'b1;
  logic [lccv_pkg::TIME_W-1:0] cur_now = '0;
  int                          stall_cnt = 0;
  int                          quiet_cycles = 0;

  // Cache behavior: apply one request to the shadow state, return its response
  function automatic cache_rsp_t cache_predict(input cache_req_t r);
    cache_rsp_t                  o;
    int                          idx;
    bit                          found;
    logic [lccv_pkg::TIME_W-1:0] oldest;
    o     = '0;
    idx   = 0;
    found = 1'b0;
    case (r.func)
      lccv_pkg::FN_LOOKUP: begin
        // only filled entries take part; first match wins
        for (int i = 0; i < cache_fill; i++) begin
          if (!found && cache_tag[i] == r.item_id) begin
            found = 1'b1;
            idx   = i;
          end
        end
        if (query_cnt != lccv_pkg::CNT_MAX) query_cnt++;
        pend_miss = !found;
        pend_idx  = idx;
        if (found) begin
          o.hit         = 1'b1;
          o.entry_index = idx[lccv_pkg::OUT_IDX_W-1:0];
          o.cached_time = cache_item_time[idx];
        end
      end
      lccv_pkg::FN_CONFIRM: begin
        o.entry_index = pend_idx[lccv_pkg::OUT_IDX_W-1:0];
        if (!pend_miss) begin
          cache_use_time[pend_idx] = r.now_time;
          if (hit_cnt != lccv_pkg::CNT_MAX) hit_cnt++;
          o.cached_time = cache_item_time[pend_idx];
        end
      end
      lccv_pkg::FN_DATA: begin
        if (!pend_miss) begin
          idx = pend_idx;
        end else if (cache_fill < lccv_pkg::CACHE_ENTRIES) begin
          idx = cache_fill;
          cache_fill++;
        end else begin
          // oldest nonzero use time strictly older than now, else entry 0
          oldest = r.now_time;
          for (int i = 0; i < lccv_pkg::CACHE_ENTRIES; i++) begin
            if (cache_use_time[i] != '0 && cache_use_time[i] < oldest) begin
              oldest = cache_use_time[i];
              idx    = i;
            end
          end
          if (!warm_st) begin
            warm_st   = 1'b1;
            query_cnt = '0;
            hit_cnt   = '0;
          end
        end
        cache_tag[idx]       = r.item_id;
        cache_item_time[idx] = r.item_time;
        cache_use_time[idx]  = r.now_time;
        o.entry_index        = idx[lccv_pkg::OUT_IDX_W-1:0];
        o.cached_time        = r.item_time;
      end
      default: ;
    endcase
    o.query_count = query_cnt;
    o.hit_count   = hit_cnt;
    o.warm        = warm_st;
    return o;
  endfunction

  function automatic cache_req_t mk_req(input logic [lccv_pkg::FUNC_W-1:0] func,
                                        input logic [lccv_pkg::ID_W-1:0] id);
    cache_req_t r;
    r.func       = func;
    r.item_id    = id;
    r.now_time   = cur_now;
    r.item_time  = $urandom();
    r.item_value = $urandom();
    r.item_class = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Mostly ids already cached, so lookups hit often
  function automatic logic [lccv_pkg::ID_W-1:0] pick_id();
    if (cache_fill > 0 && $urandom_range(0, 9) < 6)
      return cache_tag[$urandom_range(0, cache_fill - 1)];
    return lccv_pkg::ID_W'($urandom_range(0, 1023));
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // One request transfer; valid stays high so back-to-back items need no gap
  task automatic send_req(input cache_req_t r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= r.func;
    req_ch.item_id    <= r.item_id;
    req_ch.now_time   <= r.now_time;
    req_ch.item_time  <= r.item_time;
    req_ch.item_value <= r.item_value;
    req_ch.item_class <= r.item_class;
    do @(posedge clk); while (!req_ch.ready);
    expected_rsp_q.push_back(cache_predict(r));
  endtask

  // Hold off the sender until every response is back
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
  endtask

  // Empty cache, ignored confirms, duplicates, field extremes
  task automatic test_cold_start();
    cache_req_t r;
    cur_now = '0;
    send_req(mk_req(lccv_pkg::FN_CONFIRM, 10'd5));
    send_req(mk_req(FN_UNUSED, '1));
    send_req(mk_req(lccv_pkg::FN_LOOKUP, '0));
    r = mk_req(lccv_pkg::FN_DATA, '0);
    r.item_time  = '0;
    r.item_value = '0;
    r.item_class = 1'b0;
    send_req(r);
    // second reply after the same miss fills another entry with the same id
    send_req(mk_req(lccv_pkg::FN_DATA, '0));
    cur_now = 32'd1;
    send_req(mk_req(lccv_pkg::FN_LOOKUP, '1));
    r = mk_req(lccv_pkg::FN_DATA, '1);
    r.item_time  = '1;
    r.item_value = '1;
    r.item_class = 1'b1;
    send_req(r);
    // pending decision is still a miss
    send_req(mk_req(lccv_pkg::FN_CONFIRM, '1));
    cur_now = 32'd5;
    send_req(mk_req(lccv_pkg::FN_LOOKUP, '1));
    send_req(mk_req(lccv_pkg::FN_CONFIRM, '1));
    send_req(mk_req(lccv_pkg::FN_CONFIRM, '1));
    cur_now = 32'd9;
    // stale hit refreshed by a data reply
    send_req(mk_req(lccv_pkg::FN_DATA, '1));
    send_req(mk_req(lccv_pkg::FN_LOOKUP, '0));
    send_req(mk_req(lccv_pkg::FN_LOOKUP, 10'h2aa));
    send_req(mk_req(lccv_pkg::FN_LOOKUP, 10'h155));
    send_req(mk_req(FN_UNUSED, 10'h155));
    send_req(mk_req(lccv_pkg::FN_LOOKUP, '1));
  endtask

  // Fill the remaining entries at one time value so the first victim search finds none
  task automatic test_fill_and_warm();
    logic [lccv_pkg::ID_W-1:0] id;
    idle_en = 1'b1;
    while (cache_fill < lccv_pkg::CACHE_ENTRIES) begin
      id = lccv_pkg::ID_W'(100 + cache_fill);
      send_req(mk_req(lccv_pkg::FN_LOOKUP, id));
      send_req(mk_req(lccv_pkg::FN_DATA, id));
    end
    send_req(mk_req(lccv_pkg::FN_LOOKUP, 10'h300));
    send_req(mk_req(lccv_pkg::FN_DATA, 10'h300));
    cur_now = cur_now + 11;
    send_req(mk_req(lccv_pkg::FN_LOOKUP, 10'h301));
    send_req(mk_req(lccv_pkg::FN_DATA, 10'h301));
    wait_all_results();
  endtask

  // Lookup/reply sequences with random content, plus some noise
  task automatic test_random_traffic();
    int                        n;
    bit                        paused;
    logic [lccv_pkg::ID_W-1:0] id;
    cache_req_t                r;
    n      = 0;
    paused = 1'b0;
    while (n < RAND_ITEMS) begin
      idle_en = ((n / 100) % 3) != 2;
      if (!paused && n >= RAND_ITEMS / 2) begin
        wait_all_results();
        paused = 1'b1;
      end
      cur_now = cur_now + $urandom_range(0, 40);
      if ($urandom_range(0, 3) != 0) begin
        id = pick_id();
        send_req(mk_req(lccv_pkg::FN_LOOKUP, id));
        cur_now = cur_now + $urandom_range(0, 40);
        if (!pend_miss)
          send_req(mk_req(($urandom_range(0, 9) < 7) ? lccv_pkg::FN_CONFIRM
                                                     : lccv_pkg::FN_DATA, id));
        else
          send_req(mk_req(($urandom_range(0, 9) < 9) ? lccv_pkg::FN_DATA
                                                     : lccv_pkg::FN_CONFIRM, id));
        n += 2;
        // repeated reply on the same pending decision
        if ($urandom_range(0, 7) == 0) begin
          send_req(mk_req($urandom_range(0, 1) ? lccv_pkg::FN_DATA
                                               : lccv_pkg::FN_CONFIRM, id));
          n++;
        end
      end else begin
        r = mk_req(lccv_pkg::FUNC_W'($urandom_range(0, 3)),
                   lccv_pkg::ID_W'($urandom_range(0, 1023)));
        send_req(r);
        if (r.func != FN_UNUSED) n++;
      end
    end
  endtask

  // Time near and at its top value; no idling from here on
  task automatic test_time_top();
    logic [lccv_pkg::ID_W-1:0] id;
    idle_en = 1'b0;
    cur_now = 32'hFFFF_FFF0;
    repeat (12) begin
      id = pick_id();
      send_req(mk_req(lccv_pkg::FN_LOOKUP, id));
      send_req(mk_req(pend_miss ? lccv_pkg::FN_DATA : lccv_pkg::FN_CONFIRM, id));
      if (cur_now != '1) cur_now = cur_now + 1;
    end
    cur_now = '1;
    repeat (6) begin
      id = pick_id();
      send_req(mk_req(lccv_pkg::FN_LOOKUP, id));
      send_req(mk_req(lccv_pkg::FN_DATA, id));
    end
  endtask

  // Response ready with random stall bursts
  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt    <= stall_cnt - 1;
      rsp_ch.ready <= (stall_cnt == 1);
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      stall_cnt    <= $urandom_range(1, 10);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Response checker
  always @(posedge clk) begin
    cache_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp_q.size() == 0) begin
        fail_cnt++;
        $error("response transfer with no request outstanding");
      end else begin
        want = expected_rsp_q.pop_front();
        cmp_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
        cmp_field("entry_index", 32'(want.entry_index), 32'(rsp_ch.entry_index));
        cmp_field("cached_time", want.cached_time, rsp_ch.cached_time);
        cmp_field("query_count", 32'(want.query_count), 32'(rsp_ch.query_count));
        cmp_field("hit_count", 32'(want.hit_count), 32'(rsp_ch.hit_count));
        cmp_field("warm", 32'(want.warm), 32'(rsp_ch.warm));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // known values on every input from time zero
    req_ch.valid      = 1'b0;
    req_ch.func       = lccv_pkg::FN_LOOKUP;
    req_ch.item_id    = '0;
    req_ch.now_time   = '0;
    req_ch.item_time  = '0;
    req_ch.item_value = '0;
    req_ch.item_class = 1'b0;
    rsp_ch.ready      = 1'b1;
    for (int i = 0; i < lccv_pkg::CACHE_ENTRIES; i++) begin
      cache_tag[i]       = '0;
      cache_item_time[i] = '0;
      cache_use_time[i]  = '0;
    end
    cache_fill = 0;
    pend_idx   = 0;
    pend_miss  = 1'b1;
    query_cnt  = '0;
    hit_cnt    = '0;
    warm_st    = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_cold_start();
    test_fill_and_warm();
    test_random_traffic();
    test_time_top();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
design/lccv_pkg.sv
design/lccv_if.sv
design/lccv_ram.sv
design/lccv_scan.sv
design/lru_client_cache_validator_core.sv
dv/tb_lru_client_cache_validator_core.sv
